// ===== sv/arrs_pkg.sv =====
// Shared types, codes and helpers for the atomic register replica step block.
// Used by arrs_in_stage, arrs_engine and atomic_register_replica_step_top.
package arrs_pkg;

	localparam int MAX_CLIENTS = 16;
	localparam int CIDX_W      = 4;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int WORD_W      = 32;
	localparam int SEEN_CNT_W  = 5;
	localparam int RCNT_W      = 8;

	localparam int IN_DATA_W   = 136;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 144;
	localparam int OUT_USER_W  = 4;
	localparam int OUT_PAD_W   = OUT_DATA_W - (4 * WORD_W + SEEN_CNT_W + 1 + CIDX_W);

	localparam logic [CFG_W-1:0] NUM_SERVERS_RST  = 7'd3;
	localparam logic [CFG_W-1:0] MAX_FAILURES_RST = 7'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_SERVERS  = 1'b0,
		REG_MAX_FAILURES = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_RELAY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK       = 2'd0,
		KIND_RELAY     = 2'd1,
		KIND_ECHO      = 2'd2,
		KIND_RELAY_ACK = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [WORD_W-1:0] tag_ts;
		logic [WORD_W-1:0] data_value;
		logic [WORD_W-1:0] prev_value;
		logic [CIDX_W-1:0] client_index;
		logic              client_known;
		logic [WORD_W-1:0] op_counter;
	} item_t;

	typedef struct packed {
		kind_t                 reply_kind;
		logic                  ack_is_write;
		logic [WORD_W-1:0]     out_ts;
		logic [WORD_W-1:0]     out_value;
		logic [WORD_W-1:0]     out_prev_value;
		logic [SEEN_CNT_W-1:0] seen_count;
		logic                  secured;
		logic                  initiator_flag;
		logic [CIDX_W-1:0]     target_client;
		logic [WORD_W-1:0]     out_op_counter;
	} result_t;

	function automatic logic [SEEN_CNT_W-1:0] popcount(input logic [MAX_CLIENTS-1:0] bits);
		logic [SEEN_CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			n = n + SEEN_CNT_W'(bits[i]);
		end
		return n;
	endfunction

endpackage

// ===== sv/arrs_in_stage.sv =====
// Input register stage of the replica step block: holds one accepted message.
// Depends on arrs_pkg for the message type.
module arrs_in_stage
	import arrs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== sv/arrs_engine.sv =====
// Replica state and combinational decision logic: stored tag, seen set, secured flag,
// per-client relay tables. Depends on arrs_pkg.
module arrs_engine
	import arrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  item_t            item,
	input  logic [CFG_W-1:0] num_servers,
	input  logic [CFG_W-1:0] max_failures,
	output logic             has_result,
	output result_t          result
);

	logic [WORD_W-1:0]      st_ts_q;
	logic [WORD_W-1:0]      st_val_q;
	logic [WORD_W-1:0]      st_prev_q;
	logic [MAX_CLIENTS-1:0] seen_q;
	logic                   sec_q;
	logic [WORD_W-1:0]      rts_q  [MAX_CLIENTS];
	logic [RCNT_W-1:0]      rcnt_q [MAX_CLIENTS];

	logic [CIDX_W-1:0]      c;
	logic                   accepted;
	logic                   client_op;
	logic [MAX_CLIENTS-1:0] bit_c;
	logic [CFG_W-1:0]       fail;
	logic                   newer;
	logic                   same;
	logic [WORD_W-1:0]      ts_n;
	logic [WORD_W-1:0]      val_n;
	logic [WORD_W-1:0]      prev_n;
	logic [WORD_W-1:0]      rts_c;
	logic [RCNT_W-1:0]      rcnt_c;
	logic [MAX_CLIENTS-1:0] seen_w;
	logic                   sec_w;
	logic [SEEN_CNT_W-1:0]  cnt_w;
	logic [11:0]            span;
	logic                   relay_go;
	logic [MAX_CLIENTS-1:0] seen_r;
	logic [SEEN_CNT_W-1:0]  cnt_r;
	logic                   match;
	logic [RCNT_W-1:0]      rcnt_inc;
	logic                   quorum;

	logic [MAX_CLIENTS-1:0] seen_d;
	logic                   sec_d;
	logic                   rts_we;
	logic                   rcnt_we;
	logic [RCNT_W-1:0]      rcnt_d;

	assign c         = item.client_index;
	assign accepted  = item.client_known && (32'(c) < MAX_CLIENTS);
	assign client_op = (item.operation == OP_WRITE) || (item.operation == OP_READ);
	assign bit_c     = MAX_CLIENTS'(1) << c;
	assign fail      = (max_failures == '0) ? CFG_W'(1) : max_failures;
	assign newer     = st_ts_q < item.tag_ts;
	assign same      = st_ts_q == item.tag_ts;
	assign ts_n      = newer ? item.tag_ts : st_ts_q;
	assign val_n     = newer ? item.data_value : st_val_q;
	assign prev_n    = newer ? item.prev_value : st_prev_q;
	assign rts_c     = rts_q[c];
	assign rcnt_c    = rcnt_q[c];

	// client path: quotient test rewritten as N >= 2F and N < (seen + 2) * F
	assign seen_w   = (newer ? '0 : seen_q) | bit_c;
	assign sec_w    = newer ? 1'b0 : sec_q;
	assign cnt_w    = popcount(seen_w);
	assign span     = 12'(cnt_w + SEEN_CNT_W'(2)) * 12'(fail);
	assign relay_go = ({1'b0, num_servers} >= {fail, 1'b0}) && (12'(num_servers) < span)
		&& !sec_w && (rts_c < ts_n);

	// relay path
	assign seen_r   = newer ? bit_c : (same ? (seen_q | bit_c) : seen_q);
	assign cnt_r    = popcount(seen_r);
	assign match    = rts_c == item.tag_ts;
	assign rcnt_inc = (rcnt_c == '1) ? rcnt_c : rcnt_c + RCNT_W'(1);
	assign quorum   = (fail <= num_servers) && (rcnt_inc >= RCNT_W'(num_servers - fail));

	always_comb begin
		has_result             = 1'b0;
		result.reply_kind      = KIND_ACK;
		result.ack_is_write    = 1'b0;
		result.out_ts          = ts_n;
		result.out_value       = val_n;
		result.out_prev_value  = prev_n;
		result.seen_count      = '0;
		result.secured         = 1'b0;
		result.initiator_flag  = 1'b0;
		result.target_client   = c;
		result.out_op_counter  = item.op_counter;
		seen_d                 = seen_r;
		sec_d                  = sec_q;
		rts_we                 = 1'b0;
		rcnt_we                = 1'b0;
		rcnt_d                 = rcnt_inc;
		if (client_op) begin
			seen_d     = seen_w;
			sec_d      = sec_w;
			has_result = 1'b1;
			if (relay_go) begin
				rts_we            = 1'b1;
				rcnt_we           = 1'b1;
				rcnt_d            = RCNT_W'(1);
				result.reply_kind = KIND_RELAY;
			end else begin
				result.reply_kind   = KIND_ACK;
				result.ack_is_write = item.operation == OP_WRITE;
				result.seen_count   = cnt_w;
				result.secured      = sec_w;
			end
		end else if (match) begin
			rcnt_we = 1'b1;
			if (quorum) begin
				if (newer || same) begin
					sec_d = 1'b1;
				end
				has_result            = 1'b1;
				result.reply_kind     = KIND_RELAY_ACK;
				result.seen_count     = cnt_r;
				result.secured        = (newer || same) ? 1'b1 : sec_q;
				result.initiator_flag = 1'b1;
			end
		end else if (rts_c < item.tag_ts) begin
			has_result            = 1'b1;
			result.reply_kind     = KIND_ECHO;
			result.out_ts         = item.tag_ts;
			result.out_value      = item.data_value;
			result.out_prev_value = item.prev_value;
		end
		if (!accepted) begin
			has_result = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_ts_q   <= '0;
			st_val_q  <= '0;
			st_prev_q <= '0;
			seen_q    <= '0;
			sec_q     <= 1'b0;
			for (int i = 0; i < MAX_CLIENTS; i++) begin
				rts_q[i]  <= '0;
				rcnt_q[i] <= '0;
			end
		end else if (fire && accepted) begin
			st_ts_q   <= ts_n;
			st_val_q  <= val_n;
			st_prev_q <= prev_n;
			seen_q    <= seen_d;
			sec_q     <= sec_d;
			if (rts_we) begin
				rts_q[c] <= ts_n;
			end
			if (rcnt_we) begin
				rcnt_q[c] <= rcnt_d;
			end
		end
	end

endmodule

// ===== sv/atomic_register_replica_step_top.sv =====
// Replica server step of a fast-read atomic register: one decoded message in, at most
// one reply out. A message is registered in the input stage on acceptance, decided
// combinationally against the stored tag and the per-client relay tables, and its reply
// is registered in the reply register when the message leaves the input stage. One
// message is taken every cycle while the reply side keeps up; the stored state is read
// and rewritten within that cycle, which sets the rate. With the receiver stalled, the
// input stalls once the input and reply registers both hold a transaction. Messages
// from unknown clients give no reply and change nothing.
// Depends on arrs_pkg, arrs_in_stage and arrs_engine.
module atomic_register_replica_step_top
	import arrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tag_ts, data_value, prev_value, client_index, client_known, op_counter, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_ts, out_value, out_prev_value, seen_count, secured, target_client,
	// out_op_counter, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// reply_kind, ack_is_write, initiator_flag
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic [CFG_W-1:0] num_servers_q;
	logic [CFG_W-1:0] max_failures_q;
	item_t            in_item;
	item_t            item_s1;
	logic             valid_s1;
	logic             advance;
	logic             has_result;
	result_t          result;
	logic             out_valid_q;
	result_t          out_q;

	assign in_item.operation    = s_axis_tuser[1:0];
	assign in_item.tag_ts       = s_axis_tdata[31:0];
	assign in_item.data_value   = s_axis_tdata[63:32];
	assign in_item.prev_value   = s_axis_tdata[95:64];
	assign in_item.client_index = s_axis_tdata[99:96];
	assign in_item.client_known = s_axis_tdata[100];
	assign in_item.op_counter   = s_axis_tdata[132:101];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servers_q  <= NUM_SERVERS_RST;
			max_failures_q <= MAX_FAILURES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_SERVERS:  num_servers_q  <= cfg_data;
				REG_MAX_FAILURES: max_failures_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	arrs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	arrs_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.num_servers  (num_servers_q),
		.max_failures (max_failures_q),
		.has_result   (has_result),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.out_op_counter, out_q.target_client,
		out_q.secured, out_q.seen_count, out_q.out_prev_value, out_q.out_value,
		out_q.out_ts};
	assign m_axis_tuser  = {out_q.initiator_flag, out_q.ack_is_write, out_q.reply_kind};

`ifndef ASSERT_OFF
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (out_valid_q && !m_axis_tready && valid_s1))
		else $error("input stalled while result register free");

	a_initiator_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.initiator_flag == (out_q.reply_kind == KIND_RELAY_ACK)))
		else $error("initiator flag disagrees with reply kind");

	a_write_ack_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ack_is_write) |-> (out_q.reply_kind == KIND_ACK))
		else $error("write flag on a non-direct reply");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without a staged message");
`endif

endmodule
